[sv/array_linked_list_engine_assert.svh]
// Assertion macros for the array linked list engine checker.
// Depends on: a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LINKED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define ALLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define ALLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/alle_pkg.sv]
// Shared types, codes and constants of the array linked list engine.
// No dependencies; used by every module of the block.
`default_nettype none

package alle_pkg;

    localparam int SLOTS      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int STATUS_W   = 2;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t LAST_SLOT = idx_t'(SLOTS - 1);

    // Request stream: position then value in tdata, command in tuser.
    localparam int IN_FIELDS_W = IDX_W + VALUE_BITS;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_POS_LSB  = 0;
    localparam int IN_VAL_LSB  = IDX_W;

    // Result stream: status, slot, head, tail, count, free head.
    localparam int OUT_FIELDS_W   = STATUS_W + 5 * IDX_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_SLOT_LSB   = STATUS_W;
    localparam int OUT_HEAD_LSB   = STATUS_W + IDX_W;
    localparam int OUT_TAIL_LSB   = STATUS_W + 2 * IDX_W;
    localparam int OUT_COUNT_LSB  = STATUS_W + 3 * IDX_W;
    localparam int OUT_FREE_LSB   = STATUS_W + 4 * IDX_W;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_LIVE    = 2'd1,
        ST_FULL        = 2'd2,
        ST_EMPTY_AFTER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UNLINK,
        S_COMMIT
    } state_t;

    // One write into each link memory per cycle.
    typedef struct packed {
        logic nxt_we;
        idx_t nxt_addr;
        idx_t nxt_data;
        logic prv_we;
        idx_t prv_addr;
        idx_t prv_data;
    } link_wr_t;

    // Forward link of a slot that was never written since reset.
    function automatic idx_t next_reset(input idx_t a);
        idx_t r;
        if (a == '0 || a == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = a + idx_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/array_linked_list_engine.sv]
// Top level of the array linked list engine: request decode, sequencer and result register.
// Depends on alle_pkg and alle_links.
//
//  channel   | direction | handshake                    | contents
//  ----------+-----------+------------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser command, tdata position+value
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata status, slot, head, tail,
//            |           |                              | count, free head
//
// An insert passes through the lookup and commit states to load the result register and a
// remove through lookup, unlink and commit; a request rejected as not live, full or with
// nothing after the position loads it from the lookup state. Ready returns with the idle
// state. The order is set by the forward link memory: one write port and registered reads,
// with the remove needing two dependent reads. One request is in work at a time.
// Reset brings up an empty list at once: write-valid bits stand in for the link reset,
// so there is no clearing pass. A stalled result register holds the sequencer in its
// final cycle; a new request is taken while an earlier result still waits.
`default_nettype none

module array_linked_list_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [5:0] position, [37:6] value, [39:38] zero
    input  wire logic [alle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] status, [7:2] slot, [13:8] head_slot, [19:14] tail_slot,
    // [25:20] element_count, [31:26] free_slot
    output logic [alle_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import alle_pkg::*;

    localparam logic [SLOTS-1:0] LIVE_RST = {{(SLOTS-1){1'b0}}, 1'b1};

    // Request fields
    logic                  accept;
    idx_t                  in_pos;
    logic [VALUE_BITS-1:0] in_val;
    cmd_t                  in_cmd;
    status_t               accept_status;

    // Sequencer
    state_t  state_reg, state_next;
    cmd_t    cmd_reg;
    idx_t    pos_reg;
    idx_t    slot_reg;
    status_t status_reg;
    status_t lookup_status;
    logic    out_free;
    logic    emit;
    logic    commit;
    status_t emit_status;
    idx_t    emit_slot;

    // List bookkeeping
    logic [SLOTS-1:0] live_reg, live_next;
    idx_t             free_head_reg, free_head_next;
    idx_t             count_reg, count_next;
    idx_t             head_reg, head_next;
    idx_t             tail_reg, tail_next;

    // Link memory access
    logic     rd_en;
    idx_t     rd_addr_a;
    idx_t     rd_addr_b;
    idx_t     rd_a;
    idx_t     rd_b;
    link_wr_t wr;

    // Stored values; nothing on the result path reads them.
    logic [VALUE_BITS-1:0] values_mem [SLOTS];
    logic                  val_we;

    // Result register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign in_pos = s_axis_tdata[IN_POS_LSB +: IDX_W];
    assign in_val = s_axis_tdata[IN_VAL_LSB +: VALUE_BITS];
    assign in_cmd = cmd_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    // Liveness and free-chain checks need no memory read.
    always_comb
    begin
        priority if (!live_reg[in_pos])
        begin
            accept_status = ST_NOT_LIVE;
        end
        else if (in_cmd == CMD_INSERT && free_head_reg == '0)
        begin
            accept_status = ST_FULL;
        end
        else
        begin
            accept_status = ST_OK;
        end
    end

    // A remove finds out only after the first read whether anything follows the position.
    always_comb
    begin
        lookup_status = status_reg;
        if (status_reg == ST_OK && cmd_reg == CMD_REMOVE && rd_a == '0)
        begin
            lookup_status = ST_EMPTY_AFTER;
        end
    end

    alle_links u_links (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr        (wr),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (lookup_status != ST_OK)
                begin
                    if (out_free)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory access and result strobes per state.
    // Insert: read next[pos] and next[free]; link next[f], prev[f]; then next[pos], prev[after].
    // Remove: read next[pos] = d, then next[d] = after; link next[pos], prev[after];
    // then push d on the free chain.
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr_a   = in_pos;
        rd_addr_b   = free_head_reg;
        wr          = '0;
        val_we      = 1'b0;
        emit        = 1'b0;
        commit      = 1'b0;
        emit_status = ST_OK;
        emit_slot   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                rd_en  = accept;
                val_we = accept && in_cmd == CMD_INSERT && accept_status == ST_OK;
            end
            S_LOOKUP:
            begin
                if (lookup_status != ST_OK)
                begin
                    emit        = out_free;
                    emit_status = lookup_status;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    wr.nxt_we   = 1'b1;
                    wr.nxt_addr = slot_reg;
                    wr.nxt_data = rd_a;
                    wr.prv_we   = 1'b1;
                    wr.prv_addr = slot_reg;
                    wr.prv_data = pos_reg;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr_a = rd_a;
                end
            end
            S_UNLINK:
            begin
                wr.nxt_we   = 1'b1;
                wr.nxt_addr = pos_reg;
                wr.nxt_data = rd_a;
                wr.prv_we   = 1'b1;
                wr.prv_addr = rd_a;
                wr.prv_data = pos_reg;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    commit    = 1'b1;
                    emit_slot = slot_reg;
                    wr.nxt_we = 1'b1;
                    wr.prv_we = 1'b1;
                    if (cmd_reg == CMD_INSERT)
                    begin
                        wr.nxt_addr = pos_reg;
                        wr.nxt_data = slot_reg;
                        wr.prv_addr = rd_a;
                        wr.prv_data = slot_reg;
                    end
                    else
                    begin
                        wr.nxt_addr = slot_reg;
                        wr.nxt_data = free_head_reg;
                        wr.prv_addr = slot_reg;
                        wr.prv_data = '0;
                    end
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Bookkeeping that mirrors the sentinel links, the element count, the free head and the live set.
    always_comb
    begin
        live_next      = live_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        if (commit)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                live_next[slot_reg] = 1'b1;
                free_head_next      = rd_b;
                count_next          = count_reg + idx_t'(1);
                if (pos_reg == '0)
                begin
                    head_next = slot_reg;
                end
                if (rd_a == '0)
                begin
                    tail_next = slot_reg;
                end
            end
            else
            begin
                live_next[slot_reg] = 1'b0;
                free_head_next      = slot_reg;
                if (count_reg != '0)
                begin
                    count_next = count_reg - idx_t'(1);
                end
                if (pos_reg == '0)
                begin
                    head_next = rd_a;
                end
                if (rd_a == '0)
                begin
                    tail_next = pos_reg;
                end
            end
        end
    end

    // Pack the result from the post-operation state.
    always_comb
    begin
        m_tdata_next = '0;
        m_tdata_next[OUT_STATUS_LSB +: STATUS_W] = emit_status;
        m_tdata_next[OUT_SLOT_LSB   +: IDX_W]    = emit_slot;
        m_tdata_next[OUT_HEAD_LSB   +: IDX_W]    = head_next;
        m_tdata_next[OUT_TAIL_LSB   +: IDX_W]    = tail_next;
        m_tdata_next[OUT_COUNT_LSB  +: IDX_W]    = count_next;
        m_tdata_next[OUT_FREE_LSB   +: IDX_W]    = free_head_next;
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= LIVE_RST;
            free_head_reg <= idx_t'(1);
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Request capture and result payload; hold outside their strobes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= in_cmd;
            pos_reg    <= in_pos;
            status_reg <= accept_status;
            slot_reg   <= free_head_reg;
        end
        else if (state_reg == S_LOOKUP && cmd_reg == CMD_REMOVE)
        begin
            slot_reg <= rd_a;
        end
        if (emit)
        begin
            m_tdata_reg <= m_tdata_next;
        end
        if (val_we)
        begin
            values_mem[free_head_reg] <= in_val;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[sv/alle_links.sv]
// Link storage: forward and backward slot index memories of the list.
// Depends on alle_pkg; one write per memory and two registered reads of the forward links.
`default_nettype none

module alle_links (
    input  wire                logic     clk,
    input  wire                logic     rst_n,
    input  wire                logic     rd_en,
    input  wire alle_pkg::idx_t          rd_addr_a,
    input  wire alle_pkg::idx_t          rd_addr_b,
    input  wire alle_pkg::link_wr_t      wr,
    output alle_pkg::idx_t               rd_data_a,
    output alle_pkg::idx_t               rd_data_b
);
    import alle_pkg::*;

    idx_t             next_mem [SLOTS];
    idx_t             prev_mem [SLOTS];
    logic [SLOTS-1:0] next_vld_reg;
    idx_t             raw_a_reg;
    idx_t             raw_b_reg;
    idx_t             addr_a_reg;
    idx_t             addr_b_reg;
    logic             vld_a_reg;
    logic             vld_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.nxt_we)
        begin
            next_mem[wr.nxt_addr] <= wr.nxt_data;
        end
        if (wr.prv_we)
        begin
            prev_mem[wr.prv_addr] <= wr.prv_data;
        end
        if (rd_en)
        begin
            raw_a_reg  <= next_mem[rd_addr_a];
            raw_b_reg  <= next_mem[rd_addr_b];
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    // Mark written entries; an unwritten entry reads as its reset link.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_vld_reg <= '0;
            vld_a_reg    <= 1'b0;
            vld_b_reg    <= 1'b0;
        end
        else
        begin
            if (wr.nxt_we)
            begin
                next_vld_reg[wr.nxt_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_a_reg <= next_vld_reg[rd_addr_a];
                vld_b_reg <= next_vld_reg[rd_addr_b];
            end
        end
    end

    assign rd_data_a = vld_a_reg ? raw_a_reg : next_reset(addr_a_reg);
    assign rd_data_b = vld_b_reg ? raw_b_reg : next_reset(addr_b_reg);

endmodule

`default_nettype wire

[sv/alle_checker.sv]
// Port-level checker of the array linked list engine, bound to the top level.
// Depends on alle_pkg and array_linked_list_engine_assert.svh.
`default_nettype none

`include "array_linked_list_engine_assert.svh"

module alle_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [alle_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import alle_pkg::*;

    logic [STATUS_W-1:0] out_status;
    idx_t                out_slot;
    idx_t                out_head;
    idx_t                out_tail;
    idx_t                out_count;
    idx_t                out_free;

    assign out_status = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign out_slot   = m_axis_tdata[OUT_SLOT_LSB   +: IDX_W];
    assign out_head   = m_axis_tdata[OUT_HEAD_LSB   +: IDX_W];
    assign out_tail   = m_axis_tdata[OUT_TAIL_LSB   +: IDX_W];
    assign out_count  = m_axis_tdata[OUT_COUNT_LSB  +: IDX_W];
    assign out_free   = m_axis_tdata[OUT_FREE_LSB   +: IDX_W];

    // A stalled result keeps its payload.
    `ALLE_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Success touches a real slot; a rejection reports none.
    `ALLE_ASSERT_NOW(a_slot_vs_status, m_axis_tvalid, (out_status == ST_OK) == (out_slot != '0), "slot does not match status")

    // An empty list has neither head nor tail.
    `ALLE_ASSERT_NOW(a_empty_ends, m_axis_tvalid, ((out_count == '0) == (out_head == '0)) && ((out_head == '0) == (out_tail == '0)), "head, tail and count disagree")

    // The free chain runs dry exactly when every slot but the sentinel is live.
    `ALLE_ASSERT_NOW(a_free_vs_count, m_axis_tvalid, (out_free == '0) == (out_count == LAST_SLOT), "free head and count disagree")

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
